[sv/priority_inheritance_mutex_macros.svh]
// Assertion macros for the priority inheritance mutex.
// Compile with NO_ASSERTIONS defined to drop all checks.
`ifndef PRIORITY_INHERITANCE_MUTEX_MACROS_SVH
`define PRIORITY_INHERITANCE_MUTEX_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock edge.
`define PIM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pim assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define PIM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pim assertion failed");

`else

`define PIM_ASSERT_SAME(label, clk, rst, ante, cons)
`define PIM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/pim_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pim_pkg
// Shared constants, codes and sequencer states of the priority
// inheritance mutex.
// ----------------------------------------------------------------------------
package pim_pkg;

  localparam int MAX_WAITERS_DEF   = 8;
  localparam int TASK_ID_BITS_DEF  = 8;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;

  // request codes; bit 1 of the action selects unlock
  localparam logic [ACTION_W-1:0] ACT_LOCK    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TRYLOCK = 2'd1;
  localparam int                  ACT_UNLOCK_BIT = 1;

  // result codes
  localparam logic [STATUS_W-1:0] STAT_ACQUIRED   = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_TRY_BUSY   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BLOCKED    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_QUEUE_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_RELEASED   = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_HANDED_OFF = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

endpackage

[sv/priority_inheritance_mutex.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_inheritance_mutex
// Single mutex with priority inheritance and a wait table kept in arrival order.
// ----------------------------------------------------------------------------
// Lock, trylock, and unlock with no waiters: done is registered from the accepted start.
// Unlock with waiters scans the wait table one entry per cycle for the
// winner, then compacts the entries behind it through the wait table port.
// busy stays high until the sequencer returns to idle; done is one cycle.
// Synchronous active-high rst frees the mutex, empties the table and clears
// the inversion count; no clearing pass is needed.
module priority_inheritance_mutex #(
  parameter int MAX_WAITERS   = pim_pkg::MAX_WAITERS_DEF,
  parameter int TASK_ID_BITS  = pim_pkg::TASK_ID_BITS_DEF,
  parameter int PRIORITY_BITS = pim_pkg::PRIORITY_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [pim_pkg::ACTION_W-1:0]     action,
  input  logic [TASK_ID_BITS-1:0]          task_id,
  input  logic [PRIORITY_BITS-1:0]         task_priority,
  output logic                             done,
  output logic [pim_pkg::STATUS_W-1:0]     status,
  output logic                             boosted,
  output logic [TASK_ID_BITS-1:0]          owner_task,
  output logic [PRIORITY_BITS-1:0]         owner_priority_update,
  output logic                             owner_update_valid,
  output logic [TASK_ID_BITS-1:0]          woken_task,
  output logic                             woken_valid,
  output logic [31:0]                      inversion_count
);

  `include "priority_inheritance_mutex_macros.svh"

  localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CNT_W = $clog2(MAX_WAITERS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WAITERS);

  pim_pkg::state_t state, state_next;

  logic                     held;
  logic [TASK_ID_BITS-1:0]  owner_id;
  logic [PRIORITY_BITS-1:0] owner_eff;
  logic [PRIORITY_BITS-1:0] owner_base;
  logic [CNT_W-1:0]         count;
  logic [31:0]              inv_total;

  logic [IDX_W-1:0]         ptr;
  logic                     cmp_vld;
  logic [IDX_W-1:0]         cmp_idx;
  logic [IDX_W-1:0]         best_idx;
  logic [TASK_ID_BITS-1:0]  best_id;
  logic [PRIORITY_BITS-1:0] best_pri;
  logic                     sh_vld;
  logic [IDX_W-1:0]         sh_dst;

  logic                     accept;
  logic                     is_unlock;
  logic                     queue_lock;
  logic [CNT_W-1:0]         ptr_inc;
  logic                     shift_more;
  logic [IDX_W-1:0]         last_idx;
  logic                     cmp_take;
  logic [IDX_W-1:0]         best_idx_new;
  logic [TASK_ID_BITS-1:0]  best_id_new;
  logic [PRIORITY_BITS-1:0] best_pri_new;

  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [TASK_ID_BITS-1:0]  wr_id;
  logic [PRIORITY_BITS-1:0] wr_pri;
  logic [IDX_W-1:0]         rd_addr;
  logic [TASK_ID_BITS-1:0]  rd_id;
  logic [PRIORITY_BITS-1:0] rd_pri;

  pim_wait_ram #(
    .DEPTH (MAX_WAITERS),
    .ID_W  (TASK_ID_BITS),
    .PRI_W (PRIORITY_BITS),
    .AW    (IDX_W)
  ) u_wait_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_id   (wr_id),
    .wr_pri  (wr_pri),
    .rd_addr (rd_addr),
    .rd_id   (rd_id),
    .rd_pri  (rd_pri)
  );

  assign busy            = (state != pim_pkg::S_IDLE);
  assign accept          = start && !busy;
  assign is_unlock       = action[pim_pkg::ACT_UNLOCK_BIT];
  assign inversion_count = inv_total;
  assign ptr_inc         = CNT_W'(ptr) + CNT_W'(1);
  assign shift_more      = (ptr_inc < count);
  assign last_idx        = IDX_W'(count - CNT_W'(1));

  assign queue_lock = accept && !is_unlock && held && (action != pim_pkg::ACT_TRYLOCK) &&
                      (count < CNT_MAX);

  // running maximum; strict compare keeps the earliest of equal waiters
  assign cmp_take     = cmp_vld && ((cmp_idx == '0) || (rd_pri > best_pri));
  assign best_idx_new = cmp_take ? cmp_idx : best_idx;
  assign best_id_new  = cmp_take ? rd_id   : best_id;
  assign best_pri_new = cmp_take ? rd_pri  : best_pri;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pim_pkg::S_IDLE: begin
        if (accept && is_unlock && held && (count != '0)) begin
          state_next = pim_pkg::S_SCAN;
        end
      end
      pim_pkg::S_SCAN: begin
        if (cmp_vld && (cmp_idx == last_idx)) begin
          state_next = pim_pkg::S_SHIFT;
        end
      end
      pim_pkg::S_SHIFT: begin
        if (!shift_more) begin
          state_next = pim_pkg::S_FINISH;
        end
      end
      pim_pkg::S_FINISH: begin
        state_next = pim_pkg::S_IDLE;
      end
      default: begin
        state_next = pim_pkg::S_IDLE;
      end
    endcase
  end

  // table port control
  always_comb begin
    rd_addr = ptr;
    unique case (state)
      pim_pkg::S_SHIFT: rd_addr = IDX_W'(ptr_inc);
      default:          rd_addr = ptr;
    endcase
    wr_en   = queue_lock || sh_vld;
    wr_addr = sh_vld ? sh_dst : IDX_W'(count);
    wr_id   = sh_vld ? rd_id  : task_id;
    wr_pri  = sh_vld ? rd_pri : task_priority;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pim_pkg::S_IDLE;
      held      <= 1'b0;
      owner_id  <= '0;
      owner_eff <= '0;
      owner_base <= '0;
      count     <= '0;
      inv_total <= '0;
      ptr       <= '0;
      cmp_vld   <= 1'b0;
      sh_vld    <= 1'b0;
      done      <= 1'b0;
    end else begin
      state   <= state_next;
      done    <= 1'b0;
      cmp_vld <= (state == pim_pkg::S_SCAN);
      sh_vld  <= (state == pim_pkg::S_SHIFT) && shift_more;

      unique case (state)
        pim_pkg::S_IDLE: begin
          if (accept) begin
            done                  <= !(is_unlock && held && (count != '0));
            boosted               <= 1'b0;
            owner_task            <= '0;
            owner_priority_update <= '0;
            owner_update_valid    <= 1'b0;
            woken_task            <= '0;
            woken_valid           <= 1'b0;
            ptr                   <= '0;
            if (is_unlock) begin
              status <= pim_pkg::STAT_RELEASED;
              if (held && (count == '0)) begin
                // no waiter: restore the owner and free the mutex
                owner_task            <= owner_id;
                owner_priority_update <= owner_base;
                owner_update_valid    <= 1'b1;
                held                  <= 1'b0;
                owner_id              <= '0;
                owner_eff             <= '0;
                owner_base            <= '0;
              end
            end else if (!held) begin
              status     <= pim_pkg::STAT_ACQUIRED;
              held       <= 1'b1;
              owner_id   <= task_id;
              owner_eff  <= task_priority;
              owner_base <= task_priority;
            end else if (action == pim_pkg::ACT_TRYLOCK) begin
              status <= pim_pkg::STAT_TRY_BUSY;
            end else if (count >= CNT_MAX) begin
              status <= pim_pkg::STAT_QUEUE_FULL;
            end else begin
              status <= pim_pkg::STAT_BLOCKED;
              count  <= count + CNT_W'(1);
              if (task_priority > owner_eff) begin
                // inversion: boost the owner to the caller's priority
                owner_eff             <= task_priority;
                inv_total             <= inv_total + 32'd1;
                boosted               <= 1'b1;
                owner_task            <= owner_id;
                owner_priority_update <= task_priority;
                owner_update_valid    <= 1'b1;
              end
            end
          end
        end
        pim_pkg::S_SCAN: begin
          cmp_idx  <= ptr;
          best_idx <= best_idx_new;
          best_id  <= best_id_new;
          best_pri <= best_pri_new;
          if (shift_more) begin
            ptr <= ptr + IDX_W'(1);
          end
          if (cmp_vld && (cmp_idx == last_idx)) begin
            ptr <= best_idx_new;
          end
        end
        pim_pkg::S_SHIFT: begin
          // close the gap: move entry ptr+1 down to ptr
          if (shift_more) begin
            sh_dst <= ptr;
            ptr    <= ptr + IDX_W'(1);
          end
        end
        pim_pkg::S_FINISH: begin
          done                  <= 1'b1;
          status                <= pim_pkg::STAT_HANDED_OFF;
          boosted               <= 1'b0;
          owner_task            <= owner_id;
          owner_priority_update <= owner_base;
          owner_update_valid    <= 1'b1;
          woken_task            <= best_id;
          woken_valid           <= 1'b1;
          owner_id              <= best_id;
          owner_eff             <= best_pri;
          owner_base            <= best_pri;
          count                 <= count - CNT_W'(1);
        end
        default: begin
          ptr <= '0;
        end
      endcase
    end
  end

  `PIM_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNT_MAX)
  `PIM_ASSERT_SAME(a_woken_handoff, clk, rst, done,
                   woken_valid == (status == pim_pkg::STAT_HANDED_OFF))
  `PIM_ASSERT_SAME(a_boost_update, clk, rst, done && boosted,
                   owner_update_valid && (status == pim_pkg::STAT_BLOCKED))
  `PIM_ASSERT_NEXT(a_accept_progress, clk, rst, accept, done || busy)
  `PIM_ASSERT_SAME(a_scan_needs_owner, clk, rst, busy, held && (count != '0))

endmodule

[sv/pim_wait_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pim_wait_ram
// Wait table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pim_wait_ram #(
  parameter int DEPTH = pim_pkg::MAX_WAITERS_DEF,
  parameter int ID_W  = pim_pkg::TASK_ID_BITS_DEF,
  parameter int PRI_W = pim_pkg::PRIORITY_BITS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ID_W-1:0]  wr_id,
  input  logic [PRI_W-1:0] wr_pri,
  input  logic [AW-1:0]    rd_addr,
  output logic [ID_W-1:0]  rd_id,
  output logic [PRI_W-1:0] rd_pri
);

  logic [ID_W+PRI_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_id, wr_pri};
    end
  end

  always_ff @(posedge clk) begin
    {rd_id, rd_pri} <= mem[rd_addr];
  end

endmodule

[test/tb_priority_inheritance_mutex.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_inheritance_mutex
// Drives lock, trylock and unlock requests into the priority inheritance
// mutex and checks every reply against a predictor of its own. The predictor
// tracks owner, base and boosted priority, the arrival-order wait table and the
// inversion count. A directed opening covers the corner cases, then random
// request mixes fill and drain the wait table under random start gaps.
// ----------------------------------------------------------------------------
module tb_priority_inheritance_mutex;

  localparam int WAIT_DEPTH = pim_pkg::MAX_WAITERS_DEF;
  localparam int RANDOM_WORDS = 1200;
  localparam int BLOCK_WORDS = 40;

  // unlock is any code with bit 1 set
  localparam logic [pim_pkg::ACTION_W-1:0] ACT_UNLOCK       = 2'd2;
  localparam logic [pim_pkg::ACTION_W-1:0] ACT_UNLOCK_ALIAS = 2'd3;

  typedef struct packed {
    logic [pim_pkg::STATUS_W-1:0] status;
    logic                         boosted;
    logic [7:0]                   owner_task;
    logic [7:0]                   owner_pri;
    logic                         owner_valid;
    logic [7:0]                   woken_task;
    logic                         woken_valid;
    logic [31:0]                  inversions;
  } mutex_reply_t;

  class mutex_scoreboard;
    logic         held = 1'b0;
    logic [7:0]   owner_id = '0;
    logic [7:0]   eff_pri = '0;
    logic [7:0]   base_pri = '0;
    logic [7:0]   wait_ids[$];
    logic [7:0]   wait_pris[$];
    logic [31:0]  inversions = '0;
    mutex_reply_t pending_replies[$];
    int           mismatches = 0;

    function void note_request(logic [pim_pkg::ACTION_W-1:0] act, logic [7:0] id,
                               logic [7:0] pri);
      mutex_reply_t r;
      int best;
      int i;
      r = '0;
      if (act[pim_pkg::ACT_UNLOCK_BIT]) begin
        r.status = pim_pkg::STAT_RELEASED;
        if (held) begin
          r.owner_valid = 1'b1;
          r.owner_task = owner_id;
          r.owner_pri = base_pri;
          if (wait_ids.size() > 0) begin
            // highest priority wins, earliest on a tie
            best = 0;
            for (i = 1; i < wait_ids.size(); i++)
              if (wait_pris[i] > wait_pris[best]) best = i;
            r.status = pim_pkg::STAT_HANDED_OFF;
            r.woken_task = wait_ids[best];
            r.woken_valid = 1'b1;
            owner_id = wait_ids[best];
            eff_pri = wait_pris[best];
            base_pri = wait_pris[best];
            wait_ids.delete(best);
            wait_pris.delete(best);
          end else begin
            held = 1'b0;
            owner_id = '0;
            eff_pri = '0;
            base_pri = '0;
          end
        end
      end else if (!held) begin
        held = 1'b1;
        owner_id = id;
        eff_pri = pri;
        base_pri = pri;
        r.status = pim_pkg::STAT_ACQUIRED;
      end else if (act == pim_pkg::ACT_TRYLOCK) begin
        r.status = pim_pkg::STAT_TRY_BUSY;
      end else if (wait_ids.size() >= WAIT_DEPTH) begin
        r.status = pim_pkg::STAT_QUEUE_FULL;
      end else begin
        if (pri > eff_pri) begin
          eff_pri = pri;
          inversions = inversions + 32'd1;
          r.boosted = 1'b1;
          r.owner_valid = 1'b1;
          r.owner_task = owner_id;
          r.owner_pri = pri;
        end
        wait_ids.push_back(id);
        wait_pris.push_back(pri);
        r.status = pim_pkg::STAT_BLOCKED;
      end
      r.inversions = inversions;
      pending_replies.push_back(r);
    endfunction

    function void check_reply(mutex_reply_t got);
      mutex_reply_t exp;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: reply with nothing outstanding: st=%0d", $time, got.status);
        return;
      end
      exp = pending_replies.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected st=%0d bst=%0b own=%0d pri=%0d ov=%0b wk=%0d wv=%0b inv=%0d",
                   $time, exp.status, exp.boosted, exp.owner_task, exp.owner_pri,
                   exp.owner_valid, exp.woken_task, exp.woken_valid, exp.inversions);
          $display("%0t: actual   st=%0d bst=%0b own=%0d pri=%0d ov=%0b wk=%0d wv=%0b inv=%0d",
                   $time, got.status, got.boosted, got.owner_task, got.owner_pri,
                   got.owner_valid, got.woken_task, got.woken_valid, got.inversions);
        end
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic [pim_pkg::ACTION_W-1:0] action = pim_pkg::ACT_LOCK;
  logic [7:0]                   task_id = '0;
  logic [7:0]                   task_priority = '0;
  logic                         busy;
  logic                         done;
  logic [pim_pkg::STATUS_W-1:0] status;
  logic                         boosted;
  logic [7:0]                   owner_task;
  logic [7:0]                   owner_priority_update;
  logic                         owner_update_valid;
  logic [7:0]                   woken_task;
  logic                         woken_valid;
  logic [31:0]                  inversion_count;

  mutex_scoreboard sb = new();
  mutex_reply_t    seen;
  int              gap_max = 6;

  priority_inheritance_mutex dut (
    .clk                   (clk),
    .rst                   (rst),
    .start                 (start),
    .busy                  (busy),
    .action                (action),
    .task_id               (task_id),
    .task_priority         (task_priority),
    .done                  (done),
    .status                (status),
    .boosted               (boosted),
    .owner_task            (owner_task),
    .owner_priority_update (owner_priority_update),
    .owner_update_valid    (owner_update_valid),
    .woken_task            (woken_task),
    .woken_valid           (woken_valid),
    .inversion_count       (inversion_count)
  );

  always #5 clk = ~clk;

  // check a reply before noting a word taken on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        seen = '{status, boosted, owner_task, owner_priority_update, owner_update_valid,
                 woken_task, woken_valid, inversion_count};
        sb.check_reply(seen);
      end
      if (start && !busy) sb.note_request(action, task_id, task_priority);
    end
  end

  task automatic send_word(input logic [pim_pkg::ACTION_W-1:0] act, input logic [7:0] id,
                           input logic [7:0] pri);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    task_id <= id;
    task_priority <= pri;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // hold off until every reply is in, with a bound
  task automatic drain_replies();
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_replies.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic run_directed();
    int i;
    send_word(ACT_UNLOCK, 8'd0, 8'd0);                   // unlock while free
    send_word(pim_pkg::ACT_TRYLOCK, 8'd255, 8'd0);       // trylock takes a free mutex
    send_word(pim_pkg::ACT_TRYLOCK, 8'd1, 8'd255);       // trylock on held mutex
    send_word(pim_pkg::ACT_LOCK, 8'd0, 8'd0);            // equal priority, no boost
    send_word(pim_pkg::ACT_LOCK, 8'd255, 8'd100);        // owner locks again and boosts
    send_word(pim_pkg::ACT_LOCK, 8'd1, 8'd100);          // equal to boosted level
    send_word(pim_pkg::ACT_LOCK, 8'd2, 8'd255);          // boost to the top
    send_word(pim_pkg::ACT_LOCK, 8'd3, 8'd255);          // tie with earlier waiter
    for (i = 4; i < 7; i++) send_word(pim_pkg::ACT_LOCK, 8'(i), 8'(i * 20));
    send_word(pim_pkg::ACT_LOCK, 8'd7, 8'd255);          // table full
    send_word(pim_pkg::ACT_TRYLOCK, 8'd8, 8'd0);
    send_word(ACT_UNLOCK_ALIAS, 8'd9, 8'd17);   // unlock by a non-owner, code three
    for (i = 0; i < 8; i++)
      send_word((i % 2) ? ACT_UNLOCK_ALIAS : ACT_UNLOCK, 8'(i), 8'($urandom));
    send_word(ACT_UNLOCK, 8'd255, 8'd255);      // unlock while free again
    send_word(pim_pkg::ACT_LOCK, 8'd128, 8'd255);
    send_word(ACT_UNLOCK, 8'd128, 8'd0);
  endtask

  task automatic run_random();
    int n;
    int r;
    int lock_pct;
    logic tie_mode;
    logic [pim_pkg::ACTION_W-1:0] act;
    logic [7:0] pri;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % BLOCK_WORDS == 0) begin
        // mix per block: fill, balance or drain the wait table
        r = $urandom_range(0, 2);
        lock_pct = (r == 0) ? 70 : (r == 1) ? 45 : 25;
        tie_mode = ($urandom_range(0, 1) == 1);
        gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      end
      if (n % 300 == 150) drain_replies();
      r = $urandom_range(0, 99);
      if (r < lock_pct) act = pim_pkg::ACT_LOCK;
      else if (r < lock_pct + 10) act = pim_pkg::ACT_TRYLOCK;
      else act = ($urandom_range(0, 4) == 0) ? ACT_UNLOCK_ALIAS : ACT_UNLOCK;
      pri = tie_mode ? 8'($urandom_range(0, 3) << 6) : 8'($urandom);
      send_word(act, 8'($urandom), pri);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    gap_max = 6;
    run_directed();
    drain_replies();
    run_random();
    drain_replies();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/pim_pkg.sv
sv/pim_wait_ram.sv
sv/priority_inheritance_mutex.sv
test/tb_priority_inheritance_mutex.sv
